[rtl/spt_pkg.sv]
// ----------------------------------------------------------------------------
// spt_pkg: shared types and codes of the sorted priority table
// Action and status codes, stream layout widths, and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package spt_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_BITS_DEF = 16;
  localparam int ID_BITS_DEF  = 16;

  // stream field widths
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;
  localparam int FIELD_W  = 16;
  localparam int RANK_W   = 6;
  localparam int COUNT_W  = 7;
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 40;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic load;      // latch the accepted beat
    logic exec;      // decode and start the action
    logic shift;     // one step of the insert walk
    logic out_load;  // move the result into the output register
  } spt_cmd_t;

  typedef struct packed {
    logic need_shift;  // insert has stored entries to walk past
    logic shift_done;  // new entry belongs at the current position
    logic out_free;    // output register can take a result
  } spt_sts_t;

endpackage

[rtl/spt_ram.sv]
// ----------------------------------------------------------------------------
// spt_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds while
// the read enable is low.
// ----------------------------------------------------------------------------
module spt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/spt_ctrl.sv]
// ----------------------------------------------------------------------------
// spt_ctrl: sequencer of the sorted priority table
// Takes one beat, runs its action through the datapath, and hands the result
// to the output register.
// ----------------------------------------------------------------------------
module spt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  spt_pkg::spt_sts_t sts_i,
  output spt_pkg::spt_cmd_t cmd_o
);
  import spt_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    s_tready_o     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.need_shift ? S_SHIFT : S_RESP;
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (sts_i.shift_done) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/spt_dp.sv]
// ----------------------------------------------------------------------------
// spt_dp: datapath of the sorted priority table
// Holds the entry RAM, the count, the insert position and the output
// register; walks an insert down from the top, moving larger keys up by one.
// ----------------------------------------------------------------------------
module spt_dp #(
  parameter int CAPACITY = spt_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = spt_pkg::KEY_BITS_DEF,
  parameter int ID_BITS  = spt_pkg::ID_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  spt_pkg::spt_cmd_t             cmd_i,
  output spt_pkg::spt_sts_t             sts_o,
  input  logic [spt_pkg::S_DATA_W-1:0]  s_tdata_i,
  input  logic [spt_pkg::ACTION_W-1:0]  s_tuser_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [spt_pkg::M_DATA_W-1:0]  m_tdata_o,
  output logic [spt_pkg::STATUS_W-1:0]  m_tuser_o
);
  import spt_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = (CW > RANK_W) ? CW : RANK_W;
  localparam int EW = KEY_BITS + ID_BITS;

  logic [ACTION_W-1:0] action_q;
  logic [ID_BITS-1:0]  id_q;
  logic [KEY_BITS-1:0] key_q;
  logic [RANK_W-1:0]   rank_q;
  logic [CW-1:0]       count_q;
  logic [AW-1:0]       pos_q;
  logic [STATUS_W-1:0] status_q;
  logic                rd_ok_q;
  logic                m_valid_q;
  logic [M_DATA_W-1:0] m_data_q;
  logic [STATUS_W-1:0] m_user_q;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [EW-1:0]       ram_wdata, ram_rdata, new_entry;
  logic [KEY_BITS-1:0] rd_key;
  logic [ID_BITS-1:0]  rd_id;

  logic is_insert, is_read, is_clear, full, count_zero, rank_bad;
  logic key_greater, shift_done;
  logic [STATUS_W-1:0] status_d;

  assign new_entry   = {key_q, id_q};
  assign rd_key      = ram_rdata[EW-1:ID_BITS];
  assign rd_id       = ram_rdata[ID_BITS-1:0];
  assign is_insert   = (action_q == ACT_INSERT);
  assign is_read     = (action_q == ACT_READ);
  assign is_clear    = (action_q == ACT_CLEAR);
  assign full        = (count_q == CW'(CAPACITY));
  assign count_zero  = (count_q == '0);
  assign rank_bad    = (RW'(rank_q) >= RW'(count_q));
  assign key_greater = (rd_key > key_q);
  assign shift_done  = (pos_q == '0) || !key_greater;

  assign sts_o.need_shift = is_insert && !full && !count_zero;
  assign sts_o.shift_done = shift_done;
  assign sts_o.out_free   = !m_valid_q || m_tready_i;

  always_comb begin
    status_d = ST_OK;
    if (is_insert && full) begin
      status_d = ST_FULL;
    end else if (is_read && rank_bad) begin
      status_d = ST_RANGE;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = new_entry;
    ram_re    = 1'b0;
    ram_raddr = AW'(count_q - CW'(1));
    if (cmd_i.exec) begin
      if (is_insert && !full) begin
        if (count_zero) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
        end else begin
          ram_re = 1'b1;
        end
      end else if (is_read && !rank_bad) begin
        ram_re    = 1'b1;
        ram_raddr = AW'(rank_q);
      end
    end else if (cmd_i.shift) begin
      ram_we = 1'b1;
      if (!shift_done) begin
        // move the larger entry up and fetch the one below
        ram_wdata = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = pos_q - AW'(2);
      end
    end
  end

  spt_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // item and work registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= s_tuser_i;
      id_q     <= ID_BITS'(s_tdata_i[15:0]);
      key_q    <= KEY_BITS'(s_tdata_i[31:16]);
      rank_q   <= s_tdata_i[37:32];
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      rd_ok_q  <= is_read && !rank_bad;
      pos_q    <= AW'(count_q);
    end else if (cmd_i.shift && !shift_done) begin
      pos_q <= pos_q - AW'(1);
    end
    if (cmd_i.out_load) begin
      m_user_q <= status_q;
      m_data_q <= {1'b0, COUNT_W'(count_q),
                   rd_ok_q ? FIELD_W'(rd_key) : FIELD_W'(0),
                   rd_ok_q ? FIELD_W'(rd_id) : FIELD_W'(0)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec && is_clear) begin
        count_q <= '0;
      end else if (cmd_i.exec && is_insert && !full && count_zero) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.shift && shift_done) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tuser_o  = m_user_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == $past(count_q)) || (count_q == $past(count_q) + CW'(1)) ||
    (count_q == '0))
    else $error("entry count moved by more than one");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift |-> (CW'(pos_q) <= count_q) && !full)
    else $error("insert walk outside the filled region");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load && (status_q == ST_FULL) |-> full)
    else $error("full status reported on a table with room");

endmodule

[rtl/sorted_priority_table.sv]
// ----------------------------------------------------------------------------
// sorted_priority_table: stable ascending-key entry table
// Flow: read, clear, refused insert and an insert into an empty table go from
//   the beat register through the action step to the output register; any
//   other insert first walks the stored entries whose key is larger than the
//   new key (up to CAPACITY-1 of them), one entry per cycle, through the
//   single-write entry RAM.
// Handshake: one item at a time; the next beat is taken the cycle after the
//   result moves into the output register.
//   Reset clears the count and output valid; the entry RAM is not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_table #(
  parameter int CAPACITY = spt_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = spt_pkg::KEY_BITS_DEF,
  parameter int ID_BITS  = spt_pkg::ID_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // entry_id [15:0], health [31:16], rank [37:32], zero [39:38]
  input  logic [spt_pkg::S_DATA_W-1:0] s_axis_tdata,
  // action [1:0]
  input  logic [spt_pkg::ACTION_W-1:0] s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // found_id [15:0], found_health [31:16], count [38:32], zero [39]
  output logic [spt_pkg::M_DATA_W-1:0] m_axis_tdata,
  // status [1:0]
  output logic [spt_pkg::STATUS_W-1:0] m_axis_tuser
);
  import spt_pkg::*;

  spt_cmd_t cmd;
  spt_sts_t sts;

  spt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spt_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .ID_BITS  (ID_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for sorted_priority_table
// Drives insert, read, clear and unused-action beats over the input stream
// and predicts every result with a stable sorted table kept in the bench.
// Results are compared in order as they leave the output stream. The input
// side sends in bursts with gaps, and the output side stalls on its own
// pattern.
// ----------------------------------------------------------------------------
module tb;
  import spt_pkg::*;

  localparam int                  TABLE_DEPTH = 64;
  localparam logic [ACTION_W-1:0] ACT_UNUSED  = 2'd3;
  localparam int                  ITEM_GOAL   = 1550;
  localparam int                  DRAIN_WAIT  = 100;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  found_id;
    logic [FIELD_W-1:0]  found_health;
    logic [COUNT_W-1:0]  count;
  } table_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata = '0;
  logic [ACTION_W-1:0]   s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;

  // bench copy of the table
  logic [FIELD_W-1:0]    table_ids [TABLE_DEPTH];
  logic [FIELD_W-1:0]    table_keys[TABLE_DEPTH];
  int                    table_fill = 0;

  table_result_t         pending_results[$];
  int                    error_count = 0;
  int                    beats_sent = 0;
  int                    burst_left = 0;
  int                    est_fill = 0;

  sorted_priority_table u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  // Apply one beat to the bench table and return the result it must give.
  function automatic table_result_t table_step(logic [ACTION_W-1:0] action,
                                               logic [FIELD_W-1:0] entry_id,
                                               logic [FIELD_W-1:0] health,
                                               logic [RANK_W-1:0] rank);
    table_result_t res;
    int pos;
    res = '0;
    case (action)
      ACT_INSERT: begin
        if (table_fill >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          pos = table_fill;
          // shift only strictly larger keys so equal keys keep arrival order
          while (pos > 0 && table_keys[pos-1] > health) begin
            table_keys[pos] = table_keys[pos-1];
            table_ids[pos]  = table_ids[pos-1];
            pos--;
          end
          table_keys[pos] = health;
          table_ids[pos]  = entry_id;
          table_fill++;
        end
      end
      ACT_READ: begin
        if (int'(rank) >= table_fill) begin
          res.status = ST_RANGE;
        end else begin
          res.found_id     = table_ids[rank];
          res.found_health = table_keys[rank];
        end
      end
      ACT_CLEAR: begin
        table_fill = 0;
      end
      default: ;
    endcase
    res.count = table_fill[COUNT_W-1:0];
    return res;
  endfunction

  // Predict on each input beat, then check each output beat in order.
  always @(posedge clk_i) begin
    table_result_t got;
    table_result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results.push_back(table_step(s_axis_tuser, s_axis_tdata[15:0],
                                             s_axis_tdata[31:16],
                                             s_axis_tdata[37:32]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.status       = m_axis_tuser;
        got.found_id     = m_axis_tdata[15:0];
        got.found_health = m_axis_tdata[31:16];
        got.count        = m_axis_tdata[38:32];
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d id=%h health=%h count=%0d",
                   $time, got.status, got.found_id, got.found_health, got.count);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected status=%0d id=%h health=%h count=%0d",
                     $time, want.status, want.found_id, want.found_health,
                     want.count);
            $display("%0t:          actual   status=%0d id=%h health=%h count=%0d",
                     $time, got.status, got.found_id, got.found_health, got.count);
            error_count++;
          end
        end
      end
    end
  end

  // Output back-pressure: free flow, random drops, or long stalls.
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;

  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(32, 300);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (hold_left != 0) begin
          hold_left--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
          if ($urandom_range(0, 5) == 0) hold_left = $urandom_range(1, 16);
        end
      end
    endcase
  end

  // Send one beat; called at a falling edge, returns at the falling edge
  // after the beat was taken.
  task automatic send_beat(logic [ACTION_W-1:0] action, logic [FIELD_W-1:0] entry_id,
                           logic [FIELD_W-1:0] health, logic [RANK_W-1:0] rank);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = action;
    s_axis_tdata  = {2'b00, rank, health, entry_id};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    beats_sent++;
    case (action)
      ACT_INSERT: if (est_fill < TABLE_DEPTH) est_fill++;
      ACT_CLEAR:  est_fill = 0;
      default: ;
    endcase
  endtask

  task automatic test_directed_cases();
    send_beat(ACT_READ, 16'h0000, 16'h0000, 6'd0);  // read of empty table
    send_beat(ACT_INSERT, 16'hFFFF, 16'hFFFF, 6'd0);
    send_beat(ACT_INSERT, 16'h0000, 16'h0000, 6'd0);
    send_beat(ACT_INSERT, 16'h1234, 16'h8000, 6'd0);
    send_beat(ACT_INSERT, 16'h5678, 16'h8000, 6'd0);  // equal keys stay in order
    send_beat(ACT_INSERT, 16'hAAAA, 16'h8000, 6'd0);
    send_beat(ACT_INSERT, 16'h5555, 16'h7FFF, 6'd0);
    for (int r = 0; r < 6; r++) send_beat(ACT_READ, 16'hFFFF, 16'hFFFF, RANK_W'(r));
    send_beat(ACT_READ, 16'h0000, 16'h0000, 6'd6);    // rank equal to count
    send_beat(ACT_READ, 16'h0000, 16'h0000, 6'd63);
    send_beat(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 6'd63);
    send_beat(ACT_INSERT, 16'h00FF, 16'hFF00, 6'd63); // rank ignored on insert
    send_beat(ACT_READ, 16'h0000, 16'h0000, 6'd6);
    send_beat(ACT_CLEAR, 16'hFFFF, 16'hFFFF, 6'd63);
    send_beat(ACT_READ, 16'h0000, 16'h0000, 6'd0);
    send_beat(ACT_INSERT, 16'h0F0F, 16'h0001, 6'd0);
    send_beat(ACT_READ, 16'h0000, 16'h0000, 6'd0);
    send_beat(ACT_CLEAR, 16'h0000, 16'h0000, 6'd0);
  endtask

  task automatic test_full_table();
    send_beat(ACT_CLEAR, FIELD_W'($urandom), FIELD_W'($urandom), RANK_W'($urandom));
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      send_beat(ACT_INSERT, FIELD_W'($urandom), FIELD_W'($urandom_range(0, 15)),
                RANK_W'($urandom));
    end
    // refused when full
    send_beat(ACT_INSERT, FIELD_W'($urandom), 16'h0000, RANK_W'($urandom));
    send_beat(ACT_INSERT, FIELD_W'($urandom), 16'hFFFF, RANK_W'($urandom));
    send_beat(ACT_READ, FIELD_W'($urandom), FIELD_W'($urandom), 6'd63);
    send_beat(ACT_READ, FIELD_W'($urandom), FIELD_W'($urandom), 6'd0);
    for (int i = 0; i < 8; i++) begin
      send_beat(ACT_READ, FIELD_W'($urandom), FIELD_W'($urandom), RANK_W'($urandom));
    end
    send_beat(ACT_UNUSED, FIELD_W'($urandom), FIELD_W'($urandom), RANK_W'($urandom));
    send_beat(ACT_CLEAR, FIELD_W'($urandom), FIELD_W'($urandom), RANK_W'($urandom));
  endtask

  function automatic logic [FIELD_W-1:0] pick_key(int key_mode);
    case (key_mode)
      0: return FIELD_W'($urandom_range(0, 7));
      1: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  // Sessions: clear (most of the time), fill toward a random target while reading, with noise.
  task automatic test_random_sessions();
    int target;
    int key_mode;
    int pick;
    logic [RANK_W-1:0] rank;
    while (beats_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 4) != 0) begin
        send_beat(ACT_CLEAR, FIELD_W'($urandom), FIELD_W'($urandom), RANK_W'($urandom));
      end
      target   = ($urandom_range(0, 4) == 0) ? TABLE_DEPTH + $urandom_range(0, 3)
                                             : $urandom_range(1, 40);
      key_mode = $urandom_range(0, 3);
      for (int i = 0; i < 2 * target && beats_sent < ITEM_GOAL; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          send_beat(ACT_INSERT, FIELD_W'($urandom), pick_key(key_mode), RANK_W'($urandom));
        end else if (pick < 93) begin
          if (est_fill > 0 && $urandom_range(0, 6) != 0)
            rank = RANK_W'($urandom_range(0, est_fill - 1));
          else
            rank = RANK_W'($urandom);
          send_beat(ACT_READ, FIELD_W'($urandom), FIELD_W'($urandom), rank);
        end else if (pick < 98) begin
          send_beat(ACT_UNUSED, FIELD_W'($urandom), FIELD_W'($urandom), RANK_W'($urandom));
        end else begin
          send_beat(ACT_CLEAR, FIELD_W'($urandom), FIELD_W'($urandom), RANK_W'($urandom));
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed_cases();
    test_full_table();
    test_random_sessions();
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/spt_pkg.sv
rtl/spt_ram.sv
rtl/spt_ctrl.sv
rtl/spt_dp.sv
rtl/sorted_priority_table.sv
test/tb.sv
